// ===== sv/stream_filter_map_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef STREAM_FILTER_MAP_MACROS_SVH
`define STREAM_FILTER_MAP_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define SFM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfm_pkg.sv =====
package sfm_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivisorW = 16;
  localparam int unsigned CntW     = 8;
  localparam int unsigned MaxItems = 256;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFilterMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMapMode    = 2'd1;

  // filter codes
  localparam logic FilterEven  = 1'b0;
  localparam logic FilterPrime = 1'b1;

  // map codes
  localparam logic [1:0] MapIdentity = 2'd0;
  localparam logic [1:0] MapSquare   = 2'd1;
  localparam logic [1:0] MapPopcount = 2'd2;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } sfm_div_st_t;

  function automatic logic [3:0] nibble_ones(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'd0;
      4'h1, 4'h2, 4'h4, 4'h8: r = 4'd1;
      4'h3, 4'h5, 4'h6, 4'h9, 4'ha, 4'hc: r = 4'd2;
      4'h7, 4'hb, 4'hd, 4'he: r = 4'd3;
      4'hf: r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] pop_count(input logic [DataW-1:0] v);
    logic [5:0] acc;
    acc = 6'd0;
    for (int i = 0; i < DataW / 4; i++) begin
      acc = acc + 6'(nibble_ones(v[4*i +: 4]));
    end
    return acc;
  endfunction

endpackage

// ===== sv/sfm_stream_if.sv =====
interface sfm_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sfm_pkg::DataW-1:0]   sample_value;
  logic                               first_item;

  modport source (output valid, output sample_value, output first_item, input ready);
  modport sink   (input valid, input sample_value, input first_item, output ready);
endinterface

interface sfm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sfm_pkg::DataW-1:0]   mapped_value;
  logic        [sfm_pkg::CntW-1:0]    dest_index;

  modport source (output valid, output mapped_value, output dest_index, input ready);
  modport sink   (input valid, input mapped_value, input dest_index, output ready);
endinterface

// ===== sv/sfm_divider.sv =====
// Restoring remainder unit, one quotient bit per cycle
module sfm_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sfm_pkg::DataW-1:0]        dividend_i,
  input  logic [sfm_pkg::DivisorW-1:0]     divisor_i,
  output sfm_pkg::sfm_div_st_t             status_o
);

  logic [sfm_pkg::DataW-1:0]    dvd_q, dvd_d;
  logic [sfm_pkg::DivisorW-1:0] dsr_q, dsr_d;
  logic [sfm_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [5:0]                   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [sfm_pkg::DivisorW:0]   trial;

  assign trial = {rem_q, dvd_q[sfm_pkg::DataW-1]};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = 6'(sfm_pkg::DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = sfm_pkg::DivisorW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = sfm_pkg::DivisorW'(trial);
      end
      dvd_d = {dvd_q[sfm_pkg::DataW-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

endmodule

// ===== sv/sfm_map.sv =====
// Registered map stage: identity, wrapped square or population count
module sfm_map (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [sfm_pkg::DataW-1:0]    value_i,
  input  logic [1:0]                   map_mode_i,
  output logic [sfm_pkg::DataW-1:0]    mapped_o
);

  logic [sfm_pkg::DataW-1:0] square;
  logic [sfm_pkg::DataW-1:0] ones;
  logic [sfm_pkg::DataW-1:0] mapped_d, mapped_q;

  assign square = value_i * value_i;  // low word only
  assign ones   = value_i[sfm_pkg::DataW-1] ? '0
                : sfm_pkg::DataW'(sfm_pkg::pop_count(value_i));

  always_comb begin
    case (map_mode_i)
      sfm_pkg::MapSquare:   mapped_d = square;
      sfm_pkg::MapPopcount: mapped_d = ones;
      default:              mapped_d = value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mapped_q <= mapped_d;
    end
  end

  assign mapped_o = mapped_q;

endmodule

// ===== sv/stream_filter_map.sv =====
// Stream filter and map.
// Input channel in_s carries sample_value and first_item; output channel out_s
// carries mapped_value and dest_index of each kept sample. Rejected samples
// give no output transaction. cfg_we_i/cfg_idx_i/cfg_wdata_i write
// filter_mode (index 0) and map_mode (index 1); the user must do so only while
// the block is idle, which the block does not enforce. in_s.ready is high only
// while the sequencer is idle; one sample at a time. Even filter: a kept sample
// passes the map and emit states into the output register, and the input is
// ready again when it is loaded; an odd one frees it at once. Prime filter: each
// trial divisor d = 2, 3, ... with d*d <= sample takes a check step, a bit-serial
// pass through the remainder unit and a result step, so a prime sample is tried
// against every d up to its square root.
// The output register holds a finished result while out_s.ready is low; the
// sequencer waits with the next result until the register is free, and is
// not ready for new samples meanwhile.
// Reset (rst_ni low, asynchronous) clears both modes, the output index and
// all valid state. first_item restarts the output index at 0.
module stream_filter_map (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sfm_in_if.sink                        in_s,
  sfm_out_if.source                     out_s,
  input  logic                          cfg_we_i,
  input  logic [sfm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfm_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  `include "stream_filter_map_macros.svh"

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StMap   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]                       state_q, state_d;
  logic                             filter_mode_q;
  logic [1:0]                       map_mode_q;
  logic [sfm_pkg::DataW-1:0]        value_q, value_d;
  logic [sfm_pkg::DivisorW-1:0]     div_q, div_d;
  logic [sfm_pkg::DataW:0]          sq_q, sq_d;
  logic [sfm_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic [sfm_pkg::CntW:0]           cnt_inc;
  logic                             out_valid_q, out_valid_d;
  logic [sfm_pkg::CntW-1:0]         out_idx_q;
  logic [sfm_pkg::DataW-1:0]        out_val_q;
  logic [sfm_pkg::DataW-1:0]        mapped;
  logic                             in_hs, load_out, div_start, map_en;
  sfm_pkg::sfm_div_st_t             div_st;

  assign in_s.ready = (state_q == StIdle);
  assign in_hs      = in_s.valid && in_s.ready;
  assign cnt_inc    = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    div_d       = div_q;
    sq_d        = sq_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_s.ready;
    div_start   = 1'b0;
    map_en      = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_hs) begin
          value_d = in_s.sample_value;
          div_d   = sfm_pkg::DivisorW'(2);
          sq_d    = (sfm_pkg::DataW + 1)'(4);
          if (in_s.first_item) begin
            cnt_d = '0;
          end
          if (filter_mode_q == sfm_pkg::FilterPrime) begin
            // negative, zero and one are not prime
            if (in_s.sample_value > 32'sd1) begin
              state_d = StCheck;
            end
          end else if (!in_s.sample_value[0]) begin
            state_d = StMap;
          end
        end
      end
      StCheck: begin
        if (sq_q > {1'b0, value_q}) begin
          state_d = StMap;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_st.done) begin
          if (div_st.rem_zero) begin
            state_d = StIdle;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + {div_q, 1'b1};
            div_d   = div_q + 1'b1;
            state_d = StCheck;
          end
        end
      end
      StMap: begin
        map_en  = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_valid_q || out_s.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          cnt_d       = (cnt_inc >= (sfm_pkg::CntW + 1)'(sfm_pkg::MaxItems)) ? '0
                      : sfm_pkg::CntW'(cnt_inc);
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  sfm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (value_q),
    .divisor_i  (div_q),
    .status_o   (div_st)
  );

  sfm_map u_map (
    .clk_i      (clk_i),
    .en_i       (map_en),
    .value_i    (value_q),
    .map_mode_i (map_mode_q),
    .mapped_o   (mapped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      filter_mode_q <= sfm_pkg::FilterEven;
      map_mode_q    <= sfm_pkg::MapIdentity;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfm_pkg::CfgFilterMode: filter_mode_q <= cfg_wdata_i[0];
          sfm_pkg::CfgMapMode:    map_mode_q    <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    if (load_out) begin
      out_val_q <= mapped;
      out_idx_q <= cnt_q;
    end
  end

  assign out_s.valid        = out_valid_q;
  assign out_s.mapped_value = out_val_q;
  assign out_s.dest_index   = out_idx_q;

  `SFM_ASSERT(a_done_in_div, clk_i, rst_ni, !div_st.done || state_q == StDiv,
              "remainder unit finished outside the divide state")
  `SFM_ASSERT(a_divisor_min, clk_i, rst_ni,
              !(state_q == StCheck || state_q == StDiv) || div_q >= 16'd2,
              "trial divisor below two")
  `SFM_ASSERT(a_square_tracks, clk_i, rst_ni,
              !(state_q == StCheck) || sq_q == 33'(div_q) * 33'(div_q),
              "running square out of step with divisor")
  `SFM_ASSERT(a_no_overwrite, clk_i, rst_ni, !load_out || !out_valid_q || out_s.ready,
              "pending result overwritten")

endmodule

// ===== tb/sv/sfm_filter_map_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every kept sample and
// compares each output transaction against the oldest prediction.
module sfm_filter_map_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sfm_in_if                            in_mon,
  sfm_out_if                           out_mon,
  input  logic                         cfg_we_i,
  input  logic [sfm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfm_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic signed [sfm_pkg::DataW-1:0] mapped_value;
    logic        [sfm_pkg::CntW-1:0]  dest_index;
  } kept_result_t;

  kept_result_t              expected_kept [$];
  logic                      filter_mode;
  logic [1:0]                map_mode;
  logic [sfm_pkg::CntW-1:0]  kept_count;

  function automatic bit sample_is_prime(logic [sfm_pkg::DataW-1:0] v);
    longint unsigned d;
    if (v[sfm_pkg::DataW-1] || v <= 1) return 1'b0;
    // bound compared at 64 bits so d*d cannot overflow
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [sfm_pkg::DataW-1:0] map_sample(logic [sfm_pkg::DataW-1:0] v,
                                                            logic [1:0] mode);
    logic [sfm_pkg::DataW-1:0] r;
    case (mode)
      sfm_pkg::MapSquare:   r = v * v;
      sfm_pkg::MapPopcount: r = v[sfm_pkg::DataW-1] ? '0 : sfm_pkg::DataW'($countones(v));
      default:              r = v;  // unused code behaves as identity
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kept_result_t              exp_r;
    logic [sfm_pkg::DataW-1:0] v;
    bit                        keep;
    if (!rst_ni) begin
      filter_mode  = sfm_pkg::FilterEven;
      map_mode     = sfm_pkg::MapIdentity;
      kept_count   = '0;
      fail_count_o = 0;
      expected_kept.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfm_pkg::CfgFilterMode: filter_mode = cfg_wdata_i[0];
          sfm_pkg::CfgMapMode:    map_mode = cfg_wdata_i[1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        v = in_mon.sample_value;
        if (in_mon.first_item) kept_count = '0;
        keep = (filter_mode == sfm_pkg::FilterPrime) ? sample_is_prime(v) : !v[0];
        if (keep) begin
          exp_r.mapped_value = map_sample(v, map_mode);
          exp_r.dest_index   = kept_count;
          expected_kept.push_back(exp_r);
          if (int'(kept_count) + 1 >= sfm_pkg::MaxItems) kept_count = '0;
          else kept_count = kept_count + 1'b1;
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_kept.size() == 0) begin
          $display("%0t: unexpected transaction, mapped_value %0d dest_index %0d", $time,
                   out_mon.mapped_value, out_mon.dest_index);
          fail_count_o++;
        end else begin
          exp_r = expected_kept.pop_front();
          if (out_mon.mapped_value !== exp_r.mapped_value) begin
            $display("%0t: mapped_value expected %0d (0x%08h) got %0d (0x%08h)", $time,
                     exp_r.mapped_value, exp_r.mapped_value,
                     out_mon.mapped_value, out_mon.mapped_value);
            fail_count_o++;
          end
          if (out_mon.dest_index !== exp_r.dest_index) begin
            $display("%0t: dest_index expected %0d got %0d", $time,
                     exp_r.dest_index, out_mon.dest_index);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_kept.size();
    end
  end

endmodule

// ===== tb/sv/tb_stream_filter_map.sv =====
`timescale 1ns / 1ps

module tb_stream_filter_map;

  localparam int unsigned   WatchdogLimit   = 200000;
  localparam int unsigned   SettleCycles    = 16;
  localparam int unsigned   ItemsPerSetting = 12;
  localparam logic [1:0]    MapUnused       = 2'd3;
  localparam logic [sfm_pkg::CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [sfm_pkg::CfgIdxW-1:0] CfgSpare3 = 2'd3;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [sfm_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [sfm_pkg::CfgDataW-1:0] cfg_wdata;
  int                           src_idle_pct;
  int                           sink_idle_pct;
  int                           fail_count;
  int                           pending;

  logic       set_filter [6] = '{sfm_pkg::FilterEven, sfm_pkg::FilterPrime,
                                 sfm_pkg::FilterPrime, sfm_pkg::FilterEven,
                                 sfm_pkg::FilterPrime, sfm_pkg::FilterEven};
  logic [1:0] set_map    [6] = '{sfm_pkg::MapSquare, sfm_pkg::MapIdentity,
                                 sfm_pkg::MapPopcount, sfm_pkg::MapPopcount,
                                 MapUnused, sfm_pkg::MapIdentity};
  int         src_pct    [3] = '{22, 45, 0};
  int         sink_pct   [3] = '{45, 22, 0};

  sfm_in_if  in_ch ();
  sfm_out_if out_ch ();

  stream_filter_map uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_s        (in_ch),
    .out_s       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  sfm_filter_map_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
    $display("TB_ERROR");
    $finish;
  end

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic send_sample(logic [sfm_pkg::DataW-1:0] v, logic first);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.sample_value = v;
    in_ch.first_item   = first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_outputs();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // block idle: nothing pending and the sequencer back to accepting samples
  task automatic wait_idle();
    drain_outputs();
    repeat (SettleCycles) @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
  endtask

  task automatic write_reg(logic [sfm_pkg::CfgIdxW-1:0] idx,
                           logic [sfm_pkg::CfgDataW-1:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_modes(logic filt, logic [1:0] map);
    write_reg(sfm_pkg::CfgFilterMode, {1'b0, filt});
    write_reg(sfm_pkg::CfgMapMode, map);
  endtask

  // prime tests cost a remainder pass per divisor, so keep odd candidates small there
  function automatic logic [sfm_pkg::DataW-1:0] pick_sample(logic prime_mode);
    int unsigned sel;
    logic [sfm_pkg::DataW-1:0] v;
    sel = $urandom_range(99);
    if (prime_mode) begin
      if (sel < 55)      v = $urandom_range(4095);
      else if (sel < 65) v = $urandom_range(65535);
      else if (sel < 80) v = $urandom | 32'h8000_0000;
      else if (sel < 92) v = $urandom & 32'hFFFF_FFFE;
      else               v = $urandom_range(3);
    end else begin
      if (sel < 60)      v = $urandom;
      else if (sel < 80) v = sfm_pkg::DataW'($urandom_range(255)) - 32'd128;
      else if (sel < 90) begin
        case ($urandom_range(3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end else v = $urandom & 32'hFFFF_FFFE;
    end
    return v;
  endfunction

  initial begin
    int unsigned p, s, n;
    logic first;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = sfm_pkg::CfgFilterMode;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    in_ch.first_item   = 1'b0;
    src_idle_pct       = src_pct[0];
    sink_idle_pct      = sink_pct[0];
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset modes: even filter, identity map
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b0);
    send_sample(32'h0000_0002, 1'b0);

    write_reg(sfm_pkg::CfgMapMode, sfm_pkg::MapSquare);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'hFFFF_FFFE, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0000_FFFE, 1'b0);

    write_reg(sfm_pkg::CfgMapMode, sfm_pkg::MapPopcount);
    send_sample(32'hFFFF_FFFE, 1'b0);
    send_sample(32'h7FFF_FFFE, 1'b0);
    send_sample(32'h0000_0000, 1'b1);

    write_reg(sfm_pkg::CfgMapMode, MapUnused);
    send_sample(32'h0000_0006, 1'b0);

    // writes to spare indexes must leave both modes alone
    write_reg(CfgSpare2, 2'd1);
    write_reg(CfgSpare3, sfm_pkg::MapPopcount);
    send_sample(32'h0000_0008, 1'b0);
    drain_outputs();

    set_modes(sfm_pkg::FilterPrime, sfm_pkg::MapIdentity);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h0000_0002, 1'b0);
    send_sample(32'h0000_0003, 1'b0);
    send_sample(32'h0000_0004, 1'b0);
    send_sample(32'hFFFF_FFF9, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'd97, 1'b0);
    send_sample(32'h7FFF_FFFE, 1'b0);
    send_sample(32'd65521, 1'b0);
    write_reg(sfm_pkg::CfgMapMode, sfm_pkg::MapSquare);
    send_sample(32'd65521, 1'b0);
    write_reg(sfm_pkg::CfgMapMode, sfm_pkg::MapPopcount);
    send_sample(32'd131071, 1'b0);

    for (p = 0; p < 3; p++) begin
      src_idle_pct  = src_pct[p];
      sink_idle_pct = sink_pct[p];
      for (s = 2 * p; s < 2 * p + 2; s++) begin
        set_modes(set_filter[s], set_map[s]);
        for (n = 0; n < ItemsPerSetting; n++) begin
          first = (n == 0) || ($urandom_range(99) < 12);
          if ($urandom_range(99) < 4) drain_outputs();
          send_sample(pick_sample(set_filter[s] == sfm_pkg::FilterPrime), first);
        end
      end
    end

    wait_idle();
    repeat (SettleCycles) @(negedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
